### src/scp_pkg.sv
// Shared types and constants for the flux interval to SCP stream encoder.
// No dependencies; the encoder and the scaling unit in src import this package.
package scp_pkg;

    // Sequencer states of the encoder.
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_WAIT,
        S_REC,
        S_ZERO,
        S_WORD,
        S_FILL
    } t_state;

    // Register indexes on the configuration port (byte address divided by four).
    localparam logic [1:0] REG_TICK_PERIOD  = 2'd0;
    localparam logic [1:0] REG_INDEXED_MODE = 2'd1;
    localparam logic [1:0] REG_HEADER_BYTES = 2'd2;

    // Register reset values.
    localparam logic [15:0] TICK_PERIOD_RESET  = 16'd21333;
    localparam logic [15:0] HEADER_BYTES_RESET = 16'd64;

    // Scaling: ticks * period_q8 / 6400 = ((ticks * period_q8) >> 8) / 25.
    localparam int unsigned SUM_W      = 32;
    localparam int unsigned PERIOD_W   = 16;
    localparam int unsigned PROD_W     = SUM_W + PERIOD_W;
    localparam int unsigned PROD_SHIFT = 8;
    localparam int unsigned QUO_W      = PROD_W - PROD_SHIFT;
    localparam int unsigned DivConst   = 25;
    localparam int unsigned REM_W      = 5;

    // The division by 25 is a multiply by ceil(2^30 / 25) and a shift, which is exact
    // for any dividend below 2^30; it is taken once for each 20-bit half of the quotient.
    localparam int unsigned        HALF_W      = 20;
    localparam int unsigned        RECIP_W     = 26;
    localparam int unsigned        RECIP_SHIFT = 30;
    localparam logic [RECIP_W-1:0] RECIP_25    = 26'd42949673;

    // Word counter width.
    localparam int unsigned WORDS_W = 31;

endpackage

### src/scp_in_if.sv
// Input channel of the encoder: one flux event per beat.
// No dependencies.
interface scp_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] event_ticks;
    logic        has_pulse;
    logic        has_index;
    logic        end_of_stream;
    logic        new_track;

    modport source (
        output valid, event_ticks, has_pulse, has_index, end_of_stream, new_track,
        input  ready
    );
    modport sink (
        input  valid, event_ticks, has_pulse, has_index, end_of_stream, new_track,
        output ready
    );
endinterface

### src/scp_out_if.sv
// Output channel of the encoder: one flux word or revolution record per beat.
// No dependencies.
interface scp_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] flux_word;
    logic [2:0]  rev_number;
    logic [31:0] rev_offset_bytes;
    logic [30:0] rev_word_count;
    logic [31:0] rev_duration;
    logic        last;

    modport source (
        output valid, kind, flux_word, rev_number, rev_offset_bytes, rev_word_count,
               rev_duration, last,
        input  ready
    );
    modport sink (
        input  valid, kind, flux_word, rev_number, rev_offset_bytes, rev_word_count,
               rev_duration, last,
        output ready
    );
endinterface

### src/flux_interval_to_scp_encoder.sv
// Flux event to SCP stream encoder. An event is taken while the
// sequencer is idle. Each interval or revolution duration that must be scaled
// passes through the shared scaling unit: the product in the start cycle, then a
// reciprocal multiply for each half of the quotient by 25 with a remainder step
// between them, and a final step to pick the result up; at most two values are
// scaled per event. After that each result is issued once the output register
// is free. An event that produces nothing leaves the sequencer idle; the ready
// line is high only while the sequencer is idle.
// Depends on scp_pkg, scp_in_if, scp_out_if and scp_scale.
module flux_interval_to_scp_encoder
    import scp_pkg::*;
#(
    parameter int unsigned REVOLUTION_COUNT   = 5,
    parameter int unsigned MAX_OVERFLOW_WORDS = 57
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    scp_in_if.sink      i_evt,
    scp_out_if.source   o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned ZW = $clog2(MAX_OVERFLOW_WORDS + 1);
    localparam logic [QUO_W-1:0] T_LIMIT =
        QUO_W'(MAX_OVERFLOW_WORDS) * QUO_W'(65536) + QUO_W'(16'hFFFF);
    localparam logic [3:0] REV_LIMIT = 4'(REVOLUTION_COUNT);

    // Configuration registers.
    logic [15:0] r_period;
    logic        r_indexed;
    logic [15:0] r_header;

    // Track state.
    t_state             r_state, n_state;
    logic [SUM_W-1:0]   r_pulse_sum, n_pulse_sum;
    logic [SUM_W-1:0]   r_rev_sum, n_rev_sum;
    logic [2:0]         r_revs, n_revs;
    logic [WORDS_W-1:0] r_words, n_words;
    logic [WORDS_W-1:0] r_start, n_start;
    logic               r_synced, n_synced;

    // Per-event working registers.
    logic          r_pulse, n_pulse;
    logic          r_eos, n_eos;
    logic          r_ph_pulse, n_ph_pulse;
    logic [ZW-1:0] r_zeros, n_zeros;
    logic [15:0]   r_word, n_word;

    // Output register.
    logic               r_out_valid, n_out_valid;
    logic               r_out_kind, n_out_kind;
    logic [15:0]        r_out_flux, n_out_flux;
    logic [2:0]         r_out_num, n_out_num;
    logic [31:0]        r_out_off, n_out_off;
    logic [WORDS_W-1:0] r_out_cnt, n_out_cnt;
    logic [31:0]        r_out_dur, n_out_dur;
    logic               r_out_last, n_out_last;

    // Scaling unit hookup.
    logic             w_start;
    logic             w_done;
    logic [QUO_W-1:0] w_quot;
    logic [QUO_W-1:0] w_t;

    // Combinational helpers.
    logic               w_acc;
    logic               w_free;
    logic               w_cfg_wr;
    logic [2:0]         w_eff_revs;
    logic               w_eff_synced;
    logic [SUM_W-1:0]   w_eff_pulse;
    logic [SUM_W-1:0]   w_eff_rev;
    logic [SUM_W:0]     w_psum;
    logic [SUM_W:0]     w_rsum;
    logic [31:0]        w_rec_off;
    logic [WORDS_W-1:0] w_rec_cnt;
    logic [31:0]        w_dur_sat;
    logic [3:0]         w_revs_inc;

    scp_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_ticks  (r_ph_pulse ? r_pulse_sum : r_rev_sum),
        .i_period (r_period),
        .o_done   (w_done),
        .o_quot   (w_quot)
    );

    // Handshake terms, the offset and count that every record shares, and the saturated results.
    assign w_acc      = i_evt.valid && i_evt.ready;
    assign w_free     = !r_out_valid || o_res.ready;
    assign w_rec_off  = {r_start, 1'b0} + {16'b0, r_header};
    assign w_rec_cnt  = r_words - r_start;
    assign w_dur_sat  = (w_quot[QUO_W-1:32] != '0) ? 32'hFFFF_FFFF : w_quot[31:0];
    assign w_t        = (w_quot > T_LIMIT) ? T_LIMIT : w_quot;
    assign w_revs_inc = {1'b0, r_revs} + 4'd1;

    // State as seen by a new event once a new-track flag has cleared it.
    assign w_eff_revs   = i_evt.new_track ? 3'd0 : r_revs;
    assign w_eff_synced = i_evt.new_track ? 1'b0 : r_synced;
    assign w_eff_pulse  = i_evt.new_track ? '0 : r_pulse_sum;
    assign w_eff_rev    = i_evt.new_track ? '0 : r_rev_sum;
    assign w_psum       = {1'b0, w_eff_pulse} + {17'b0, i_evt.event_ticks};
    assign w_rsum       = {1'b0, w_eff_rev} + {17'b0, i_evt.event_ticks};

    // Sequencer: next state, track state and output beat.
    always_comb begin
        n_state     = r_state;
        n_pulse_sum = r_pulse_sum;
        n_rev_sum   = r_rev_sum;
        n_revs      = r_revs;
        n_words     = r_words;
        n_start     = r_start;
        n_synced    = r_synced;
        n_pulse     = r_pulse;
        n_eos       = r_eos;
        n_ph_pulse  = r_ph_pulse;
        n_zeros     = r_zeros;
        n_word      = r_word;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_kind  = r_out_kind;
        n_out_flux  = r_out_flux;
        n_out_num   = r_out_num;
        n_out_off   = r_out_off;
        n_out_cnt   = r_out_cnt;
        n_out_dur   = r_out_dur;
        n_out_last  = r_out_last;
        w_start     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_pulse = i_evt.has_pulse;
                    n_eos   = i_evt.end_of_stream;
                    if (i_evt.new_track) begin
                        n_pulse_sum = '0;
                        n_rev_sum   = '0;
                        n_revs      = '0;
                        n_words     = '0;
                        n_start     = '0;
                        n_synced    = 1'b0;
                    end
                    if ({1'b0, w_eff_revs} >= REV_LIMIT) begin
                        n_state = S_IDLE;
                    end else if (r_indexed && !w_eff_synced) begin
                        // Waiting for the first index: no words, only fillers at the end.
                        if (i_evt.has_index) begin
                            n_synced = 1'b1;
                        end
                        if (i_evt.end_of_stream) begin
                            n_state = S_FILL;
                        end
                    end else begin
                        n_pulse_sum = w_psum[SUM_W] ? '1 : w_psum[SUM_W-1:0];
                        n_rev_sum   = w_rsum[SUM_W] ? '1 : w_rsum[SUM_W-1:0];
                        if (i_evt.end_of_stream || i_evt.has_index) begin
                            n_ph_pulse = 1'b0;
                            n_state    = S_MUL;
                        end else if (i_evt.has_pulse) begin
                            n_ph_pulse = 1'b1;
                            n_state    = S_MUL;
                        end
                    end
                end
            end

            S_MUL: begin
                w_start = 1'b1;
                n_state = S_WAIT;
            end

            S_WAIT: begin
                if (w_done) begin
                    if (!r_ph_pulse) begin
                        n_state = S_REC;
                    end else begin
                        n_zeros = w_t[16 +: ZW];
                        n_word  = w_t[15:0];
                        n_state = (w_t[16 +: ZW] != '0) ? S_ZERO : S_WORD;
                    end
                end
            end

            S_REC: begin
                if (w_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = 1'b1;
                    n_out_flux  = '0;
                    n_out_num   = r_revs;
                    n_out_off   = w_rec_off;
                    n_out_cnt   = w_rec_cnt;
                    n_out_dur   = w_dur_sat;
                    n_out_last  = !r_pulse && !(r_eos && (w_revs_inc < REV_LIMIT));
                    n_revs      = w_revs_inc[2:0];
                    n_start     = r_words;
                    n_rev_sum   = '0;
                    if (r_pulse) begin
                        n_ph_pulse = 1'b1;
                        n_state    = S_MUL;
                    end else if (r_eos && (w_revs_inc < REV_LIMIT)) begin
                        n_state = S_FILL;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end

            S_ZERO: begin
                if (w_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = 1'b0;
                    n_out_flux  = '0;
                    n_out_num   = '0;
                    n_out_off   = '0;
                    n_out_cnt   = '0;
                    n_out_dur   = '0;
                    n_out_last  = 1'b0;
                    n_words     = r_words + WORDS_W'(1);
                    n_zeros     = r_zeros - ZW'(1);
                    if (r_zeros == ZW'(1)) begin
                        n_state = S_WORD;
                    end
                end
            end

            S_WORD: begin
                if (w_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = 1'b0;
                    n_out_flux  = r_word;
                    n_out_num   = '0;
                    n_out_off   = '0;
                    n_out_cnt   = '0;
                    n_out_dur   = '0;
                    n_out_last  = !(r_eos && ({1'b0, r_revs} < REV_LIMIT));
                    n_words     = r_words + WORDS_W'(1);
                    n_pulse_sum = '0;
                    n_state     = (r_eos && ({1'b0, r_revs} < REV_LIMIT)) ? S_FILL : S_IDLE;
                end
            end

            S_FILL: begin
                if (w_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = 1'b1;
                    n_out_flux  = '0;
                    n_out_num   = r_revs;
                    n_out_off   = w_rec_off;
                    n_out_cnt   = w_rec_cnt;
                    n_out_dur   = '0;
                    n_out_last  = (w_revs_inc >= REV_LIMIT);
                    n_revs      = w_revs_inc[2:0];
                    n_start     = r_words;
                    n_rev_sum   = '0;
                    n_state     = (w_revs_inc >= REV_LIMIT) ? S_IDLE : S_FILL;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pulse_sum <= '0;
            r_rev_sum   <= '0;
            r_revs      <= '0;
            r_words     <= '0;
            r_start     <= '0;
            r_synced    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pulse_sum <= n_pulse_sum;
            r_rev_sum   <= n_rev_sum;
            r_revs      <= n_revs;
            r_words     <= n_words;
            r_start     <= n_start;
            r_synced    <= n_synced;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and output payload registers.
    always_ff @(posedge i_clk) begin
        r_pulse    <= n_pulse;
        r_eos      <= n_eos;
        r_ph_pulse <= n_ph_pulse;
        r_zeros    <= n_zeros;
        r_word     <= n_word;
        r_out_kind <= n_out_kind;
        r_out_flux <= n_out_flux;
        r_out_num  <= n_out_num;
        r_out_off  <= n_out_off;
        r_out_cnt  <= n_out_cnt;
        r_out_dur  <= n_out_dur;
        r_out_last <= n_out_last;
    end

    // Configuration writes complete in the access phase.
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= TICK_PERIOD_RESET;
            r_indexed <= 1'b0;
            r_header  <= HEADER_BYTES_RESET;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_TICK_PERIOD:  r_period  <= pwdata[15:0];
                REG_INDEXED_MODE: r_indexed <= pwdata[0];
                REG_HEADER_BYTES: r_header  <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (paddr[3:2])
            REG_TICK_PERIOD:  prdata = {16'b0, r_period};
            REG_INDEXED_MODE: prdata = {31'b0, r_indexed};
            REG_HEADER_BYTES: prdata = {16'b0, r_header};
            default:          prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // Channel outputs.
    assign i_evt.ready            = (r_state == S_IDLE);
    assign o_res.valid            = r_out_valid;
    assign o_res.kind             = r_out_kind;
    assign o_res.flux_word        = r_out_flux;
    assign o_res.rev_number       = r_out_num;
    assign o_res.rev_offset_bytes = r_out_off;
    assign o_res.rev_word_count   = r_out_cnt;
    assign o_res.rev_duration     = r_out_dur;
    assign o_res.last             = r_out_last;

endmodule

### src/scp_scale.sv
// Shared scaling unit: one multiplier forms ticks * period, then divides by 25 in two
// reciprocal multiplies. Depends on scp_pkg for widths and constants.
module scp_scale
    import scp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [SUM_W-1:0]    i_ticks,
    input  logic [PERIOD_W-1:0] i_period,
    output logic                o_done,
    output logic [QUO_W-1:0]    o_quot
);

    localparam int unsigned MUL_W = SUM_W + RECIP_W;

    // Steps after the start cycle.
    localparam logic [1:0] STEP_HI  = 2'd0;
    localparam logic [1:0] STEP_REM = 2'd1;
    localparam logic [1:0] STEP_LO  = 2'd2;

    logic              r_busy;
    logic              r_done;
    logic [1:0]        r_step;
    logic [QUO_W-1:0]  r_dvd;
    logic [HALF_W-1:0] r_qhi;
    logic [REM_W-1:0]  r_rhi;
    logic [HALF_W-1:0] r_qlo;

    logic [SUM_W-1:0]   w_mul_a;
    logic [RECIP_W-1:0] w_mul_b;
    logic [MUL_W-1:0]   w_prod;
    logic [HALF_W-1:0]  w_qx25;
    logic [HALF_W-1:0]  w_rem;

    // Operand selection for the one multiplier: the product in the start cycle,
    // then the upper half of the dividend, then the remainder joined to the lower half.
    always_comb begin
        if (i_start) begin
            w_mul_a = i_ticks;
            w_mul_b = {{(RECIP_W - PERIOD_W){1'b0}}, i_period};
        end else if (r_step == STEP_HI) begin
            w_mul_a = {{(SUM_W - HALF_W){1'b0}}, r_dvd[QUO_W-1 -: HALF_W]};
            w_mul_b = RECIP_25;
        end else begin
            w_mul_a = {{(SUM_W - HALF_W - REM_W){1'b0}}, r_rhi, r_dvd[HALF_W-1:0]};
            w_mul_b = RECIP_25;
        end
    end

    assign w_prod = {{RECIP_W{1'b0}}, w_mul_a} * {{SUM_W{1'b0}}, w_mul_b};
    assign w_qx25 = r_qhi * HALF_W'(DivConst);
    assign w_rem  = r_dvd[QUO_W-1 -: HALF_W] - w_qx25;

    // Control: busy for three steps, done pulses after the last one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && (r_step == STEP_LO);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_HI;
            end else if (r_busy) begin
                if (r_step == STEP_LO) begin
                    r_busy <= 1'b0;
                end
                r_step <= r_step + 2'd1;
            end
        end
    end

    // Datapath: the shifted product is the dividend, and each half of the quotient
    // is the top bits of a reciprocal product.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= w_prod[PROD_W-1:PROD_SHIFT];
        end else if (r_busy) begin
            case (r_step)
                STEP_HI:  r_qhi <= w_prod[RECIP_SHIFT +: HALF_W];
                STEP_REM: r_rhi <= w_rem[REM_W-1:0];
                STEP_LO:  r_qlo <= w_prod[RECIP_SHIFT +: HALF_W];
                default: begin
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quot = {r_qhi, r_qlo};

endmodule

### bench/testbench.sv
// Self-checking bench for the flux interval to SCP stream encoder: queued flux events with
// bursty valid, a stalling result sink, and an in-bench encoder that predicts every beat.
// Depends on scp_pkg, scp_in_if, scp_out_if and flux_interval_to_scp_encoder.
module testbench;
    import scp_pkg::*;

    localparam int unsigned REV_COUNT    = 5;
    localparam int unsigned MAX_ZEROS    = 57;
    localparam logic [63:0] T_LIMIT      = (64'(MAX_ZEROS) << 16) | 64'hFFFF;
    localparam logic        KIND_WORD    = 1'b0;
    localparam logic        KIND_REV     = 1'b1;
    localparam int unsigned SETTLE       = 200;
    localparam int unsigned CYCLE_LIMIT  = 3_000_000;
    localparam int unsigned LONG_EVENTS  = 8;

    typedef struct packed {
        logic [15:0] ticks;
        logic        pulse;
        logic        index;
        logic        eos;
        logic        newtr;
    } flux_event_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] flux_word;
        logic [2:0]  rev_number;
        logic [31:0] rev_offset_bytes;
        logic [30:0] rev_word_count;
        logic [31:0] rev_duration;
        logic        last;
    } scp_beat_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    scp_in_if  evt_if ();
    scp_out_if res_if ();

    flux_interval_to_scp_encoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Register mirror and encoder state of the predictor.
    logic [15:0] m_period = TICK_PERIOD_RESET;
    logic        m_indexed = 1'b0;
    logic [15:0] m_hdr = HEADER_BYTES_RESET;
    logic [31:0] pulse_sum = '0;
    logic [31:0] rev_sum = '0;
    int unsigned revs_done = 0;
    logic [30:0] words = '0;
    logic [30:0] rev_start = '0;
    logic        synced = 1'b0;

    flux_event_t event_q[$];
    scp_beat_t   predicted_stream[$];

    bit          drv_active = 1'b0;
    bit          evt_taken = 1'b0;
    flux_event_t drv_item;
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    bit          gaps_on = 1'b1;
    bit          stalls_on = 1'b1;
    int unsigned err_cnt = 0;
    int unsigned cycle_cnt = 0;

    // Clock.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Ticks times the Q8 period, in 25 ns units.
    function automatic logic [63:0] scale_ticks(logic [31:0] ticks);
        return (64'(ticks) * 64'(m_period)) / 64'd6400;
    endfunction

    function automatic logic [31:0] sat_add(logic [31:0] a, logic [15:0] b);
        logic [32:0] s;
        s = {1'b0, a} + 33'(b);
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Builds a revolution record and opens the next revolution.
    function automatic scp_beat_t close_revolution(logic [31:0] dur);
        scp_beat_t r;
        r                  = '0;
        r.kind             = KIND_REV;
        r.rev_number       = 3'(revs_done);
        r.rev_offset_bytes = {rev_start, 1'b0} + 32'(m_hdr);
        r.rev_word_count   = words - rev_start;
        r.rev_duration     = dur;
        revs_done++;
        rev_start = words;
        rev_sum   = '0;
        return r;
    endfunction

    // Works out the beats that one accepted event causes.
    function automatic void encode_event(flux_event_t ev);
        scp_beat_t   beats[$];
        scp_beat_t   w;
        logic [63:0] t;
        logic [31:0] zeros;
        int unsigned i;
        if (ev.newtr) begin
            pulse_sum = '0;
            rev_sum   = '0;
            revs_done = 0;
            words     = '0;
            rev_start = '0;
            synced    = 1'b0;
        end
        if (revs_done >= REV_COUNT) return;
        if (m_indexed && !synced) begin
            // Waiting for the first index: no words are encoded, only fillers at the end.
            if (ev.index) synced = 1'b1;
            if (ev.eos) begin
                while (revs_done < REV_COUNT) beats.push_back(close_revolution('0));
            end
        end else begin
            pulse_sum = sat_add(pulse_sum, ev.ticks);
            rev_sum   = sat_add(rev_sum, ev.ticks);
            if (ev.eos || ev.index) begin
                t = scale_ticks(rev_sum);
                beats.push_back(close_revolution((t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0]));
            end
            if (ev.pulse) begin
                t = scale_ticks(pulse_sum);
                if (t > T_LIMIT) t = T_LIMIT;
                zeros = t[47:16];
                w = '0;
                w.kind = KIND_WORD;
                for (i = 0; i < zeros; i++) beats.push_back(w);
                w.flux_word = t[15:0];
                beats.push_back(w);
                words     = words + zeros[30:0] + 31'd1;
                pulse_sum = '0;
            end
            if (ev.eos) begin
                while (revs_done < REV_COUNT) beats.push_back(close_revolution('0));
            end
        end
        if (beats.size() > 0) beats[beats.size() - 1].last = 1'b1;
        foreach (beats[j]) predicted_stream.push_back(beats[j]);
    endfunction

    // Register write over the configuration port; the mirror follows it.
    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TICK_PERIOD:  m_period  = value[15:0];
            REG_INDEXED_MODE: m_indexed = value[0];
            REG_HEADER_BYTES: m_hdr     = value[15:0];
            default: ;
        endcase
    endtask

    task automatic add_event(input logic [15:0] ticks, input logic pulse, input logic index,
                             input logic eos, input logic newtr);
        flux_event_t ev;
        ev = '{ticks: ticks, pulse: pulse, index: index, eos: eos, newtr: newtr};
        event_q.push_back(ev);
    endtask

    // Waits until every queued event is taken and every predicted beat has arrived.
    task automatic drain();
        while (event_q.size() != 0 || drv_active || predicted_stream.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Random tracks: mostly whole tracks, some broken ones and some loose noise.
    task automatic add_random(input int unsigned n_items);
        int unsigned done_items;
        int unsigned len;
        int unsigned sel;
        int unsigned k;
        logic [15:0] ticks;
        done_items = 0;
        while (done_items < n_items) begin
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                add_event(16'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
                done_items++;
            end else begin
                len = $urandom_range(2, 18);
                for (k = 0; k < len; k++) begin
                    if ($urandom_range(0, 3) == 0) ticks = 16'($urandom);
                    else ticks = 16'($urandom_range(0, 400));
                    add_event(ticks,
                              $urandom_range(0, 7) != 0,
                              (k == 1 && $urandom_range(0, 1) == 1) || $urandom_range(0, 9) == 0,
                              (sel == 1) ? ($urandom_range(0, 5) == 0) : (k == len - 1),
                              (sel != 1) && (k == 0));
                end
                done_items += len;
            end
        end
    endtask

    // Stimulus sequence: directed phases, a long revolution at full rate, then random settings.
    initial begin
        int unsigned p;
        int unsigned n;
        i_rst_n                = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        evt_if.valid           = 1'b0;
        evt_if.event_ticks     = '0;
        evt_if.has_pulse       = 1'b0;
        evt_if.has_index       = 1'b0;
        evt_if.end_of_stream   = 1'b0;
        evt_if.new_track       = 1'b0;
        res_if.ready           = 1'b1;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: short and long intervals, records, fillers, completed track.
        add_event(16'd0, 1'b1, 1'b0, 1'b0, 1'b1);
        add_event(16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0);
        add_event(16'd1, 1'b1, 1'b0, 1'b0, 1'b0);
        add_event(16'd100, 1'b0, 1'b0, 1'b0, 1'b0);
        add_event(16'd100, 1'b1, 1'b0, 1'b0, 1'b0);
        add_event(16'd500, 1'b1, 1'b1, 1'b0, 1'b0);
        add_event(16'd700, 1'b0, 1'b1, 1'b0, 1'b0);
        add_event(16'd300, 1'b1, 1'b0, 1'b1, 1'b0);
        add_event(16'd10, 1'b1, 1'b0, 1'b0, 1'b0);
        add_event(16'd10, 1'b0, 1'b1, 1'b1, 1'b0);
        add_event(16'd50, 1'b0, 1'b0, 1'b1, 1'b1);
        add_event(16'd40, 1'b1, 1'b1, 1'b0, 1'b1);
        for (n = 0; n < 5; n++) add_event(16'd40, 1'b1, 1'b1, 1'b0, 1'b0);
        drain();

        // Indexed mode, largest period and header: waiting for index and the longest interval.
        cfg_write(REG_TICK_PERIOD, 32'd65535);
        cfg_write(REG_INDEXED_MODE, 32'd1);
        cfg_write(REG_HEADER_BYTES, 32'd65535);
        add_event(16'd20, 1'b1, 1'b0, 1'b1, 1'b1);
        add_event(16'd20, 1'b1, 1'b0, 1'b0, 1'b1);
        add_event(16'd30, 1'b1, 1'b1, 1'b0, 1'b0);
        add_event(16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0);
        add_event(16'd0, 1'b0, 1'b1, 1'b0, 1'b1);
        for (n = 0; n < 5; n++) add_event(16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0);
        add_event(16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b0);
        drain();
        add_random(25);
        drain();

        // Smallest period, no header.
        cfg_write(REG_TICK_PERIOD, 32'd1);
        cfg_write(REG_INDEXED_MODE, 32'd0);
        cfg_write(REG_HEADER_BYTES, 32'd0);
        add_event(16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b1);
        add_event(16'd6399, 1'b1, 1'b0, 1'b0, 1'b0);
        add_event(16'hFFFF, 1'b0, 1'b1, 1'b1, 1'b0);
        drain();
        add_random(25);
        drain();

        // A long revolution at the largest period, at full rate.
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        cfg_write(REG_TICK_PERIOD, 32'd65535);
        add_event(16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b1);
        for (n = 0; n < LONG_EVENTS; n++) add_event(16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0);
        add_event(16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b0);
        drain();

        // Random settings; some phases without idling on one side or the other.
        for (p = 0; p < 4; p++) begin
            gaps_on   = (p != 1);
            stalls_on = (p != 2);
            case ($urandom_range(0, 3))
                0: cfg_write(REG_TICK_PERIOD, 32'd1);
                1: cfg_write(REG_TICK_PERIOD, 32'd65535);
                2: cfg_write(REG_TICK_PERIOD, 32'(TICK_PERIOD_RESET));
                default: cfg_write(REG_TICK_PERIOD, 32'($urandom_range(1, 65535)));
            endcase
            cfg_write(REG_INDEXED_MODE, 32'($urandom_range(0, 1)));
            cfg_write(REG_HEADER_BYTES, 32'($urandom_range(0, 65535)));
            add_random(25);
            drain();
        end

        if (predicted_stream.size() != 0) err_cnt++;
        if (err_cnt == 0) begin
            $display("[flux_interval_to_scp_encoder] OK");
        end else begin
            $display("[flux_interval_to_scp_encoder] ERROR");
        end
        $finish;
    end

    // Event driver: bursts of back-to-back beats separated by random gaps.
    always @(negedge i_clk) begin
        if (drv_active && evt_taken) begin
            drv_active = 1'b0;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                if (!gaps_on) gap_left = 0;
                else if ($urandom_range(0, 3) == 0) gap_left = $urandom_range(10, 60);
                else gap_left = $urandom_range(0, 4);
            end
        end
        if (!drv_active) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (event_q.size() > 0) begin
                drv_item = event_q.pop_front();
                drv_active = 1'b1;
                evt_if.event_ticks   <= drv_item.ticks;
                evt_if.has_pulse     <= drv_item.pulse;
                evt_if.has_index     <= drv_item.index;
                evt_if.end_of_stream <= drv_item.eos;
                evt_if.new_track     <= drv_item.newtr;
            end
        end
        evt_if.valid <= drv_active;
    end

    // Result sink: stalls of random length on its own pattern.
    always @(negedge i_clk) begin
        if (stall_left > 0) stall_left--;
        else if (stalls_on && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 9);
        res_if.ready <= (stall_left == 0);
    end

    // Monitor: checks each result beat against the oldest prediction, then predicts
    // the beats of an event taken on this edge.
    always @(posedge i_clk) begin
        scp_beat_t got;
        scp_beat_t want;
        evt_taken = i_rst_n && evt_if.valid && evt_if.ready;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = '{kind: res_if.kind, flux_word: res_if.flux_word,
                    rev_number: res_if.rev_number, rev_offset_bytes: res_if.rev_offset_bytes,
                    rev_word_count: res_if.rev_word_count, rev_duration: res_if.rev_duration,
                    last: res_if.last};
            if (predicted_stream.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10) $display("unexpected beat: %p", got);
            end else begin
                want = predicted_stream.pop_front();
                if (got.kind !== want.kind || got.flux_word !== want.flux_word ||
                    got.rev_number !== want.rev_number ||
                    got.rev_offset_bytes !== want.rev_offset_bytes ||
                    got.rev_word_count !== want.rev_word_count ||
                    got.rev_duration !== want.rev_duration || got.last !== want.last) begin
                    err_cnt++;
                    if (err_cnt <= 10) $display("beat mismatch: expected %p, got %p", want, got);
                end
            end
        end
        if (evt_taken) encode_event(drv_item);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("[flux_interval_to_scp_encoder] ERROR");
            $finish;
        end
    end

endmodule

### sim.f
src/scp_pkg.sv
src/scp_in_if.sv
src/scp_out_if.sv
src/scp_scale.sv
src/flux_interval_to_scp_encoder.sv
bench/testbench.sv
